[rtl/averaging_voltmeter_display_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the averaging voltmeter display core
// Shared immediate-free concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef AVERAGING_VOLTMETER_DISPLAY_CORE_DEFINES_SVH
`define AVERAGING_VOLTMETER_DISPLAY_CORE_DEFINES_SVH

// Condition implies consequence in the same cycle
`define AVD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle
`define AVD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/avd_pkg.sv]
// ----------------------------------------------------------------------------
// avd_pkg
// Constants, codes and the digit decoder of the averaging voltmeter display.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package avd_pkg;

   // Field widths
   localparam int unsigned SAMPLE_W   = 10;
   localparam int unsigned SEG_W      = 7;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned TENTHS_W   = 6;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 8;

   // Default group size
   localparam int unsigned SAMPLES_DEFAULT = 4;

   // Item kinds carried on req_tuser
   localparam logic MODE_SAMPLE  = 1'b0;
   localparam logic MODE_REFRESH = 1'b1;

   // Digit select codes carried on rsp_tuser
   localparam logic DIGIT_UNITS = 1'b0;
   localparam logic DIGIT_TENS  = 1'b1;

   // Scaling of the average to tenths of a volt: (avg*33+511)/1023
   localparam int unsigned SCALE_MUL = 33;
   localparam int unsigned SCALE_RND = 511;
   localparam int unsigned SCALE_DIV = 1023;
   localparam int unsigned SCALE_SHR = 10;
   localparam int unsigned SCALE_W   = 16;
   localparam int unsigned TENTHS_MAX = 33;

   typedef logic [SEG_W-1:0]   seg_type;
   typedef logic [DIGIT_W-1:0] digit_type;

   // Seven-segment pattern, bit0=a .. bit6=g, blank above nine
   function automatic seg_type digit_code(input digit_type d);
      seg_type s;
      unique case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h6F;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

[rtl/averaging_voltmeter_display_core.sv]
// ----------------------------------------------------------------------------
// averaging_voltmeter_display_core
// Averages converter samples in groups and drives a two-digit display.
// ----------------------------------------------------------------------------
// The core takes one beat per clock on the req_ stream while req_tready is
// high: a converter sample (req_tuser = 0) or a display refresh tick
// (req_tuser = 1). Every SAMPLES samples the group average is scaled to
// tenths of a volt (0 to 33) and held. Each refresh tick returns one rsp_
// beat with the segment pattern of one digit and which digit it is, units
// first, then alternating. Samples return nothing. Throughput is one beat per
// cycle while req_tready is high. A tick passes through the input register,
// the group accumulate, divide by SAMPLES and scale stage registers and the
// output register before its result appears on rsp_tvalid.
// A two-entry output buffer lets input flow on while a result waits;
// req_tready drops only when both entries are occupied.
`timescale 1ns / 1ps
`default_nettype none
`include "averaging_voltmeter_display_core_defines.svh"

module averaging_voltmeter_display_core #(
   parameter int unsigned SAMPLES = avd_pkg::SAMPLES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [avd_pkg::REQ_DATA_W-1:0]    req_tdata,  // [9:0] sample
   input  wire logic                              req_tuser,  // [0] mode
   // Response stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [avd_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // [6:0] segments
   output logic                                   rsp_tuser   // [0] digit_select
);

   // Derived widths and the reciprocal for the group divide
   localparam int unsigned CNT_W  = (SAMPLES > 2) ? $clog2(SAMPLES) : 1;
   localparam int unsigned LOG_S  = $clog2(SAMPLES);
   localparam int unsigned SUM_W  = avd_pkg::SAMPLE_W + LOG_S;
   localparam int unsigned DIV_K  = SUM_W + 4;
   localparam int unsigned DIV_M  = ((1 << DIV_K) + SAMPLES - 1) / SAMPLES;
   localparam int unsigned M_W    = DIV_K - LOG_S + 2;
   localparam int unsigned PROD_W = SUM_W + M_W;
   localparam int unsigned SW     = avd_pkg::SAMPLE_W;
   localparam int unsigned XW     = avd_pkg::SCALE_W;
   localparam int unsigned TW     = avd_pkg::TENTHS_W;
   localparam int unsigned DW     = avd_pkg::DIGIT_W;
   localparam int unsigned QW     = XW - avd_pkg::SCALE_SHR;

   logic en;

   // Input register
   logic          in_valid_ff, in_valid_in;
   logic          in_mode_ff,  in_mode_in;
   logic [SW-1:0] in_sample_ff, in_sample_in;

   // Accumulate stage
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_add;
   logic             is_sample, is_tick, group_last;
   logic             a_done_ff, a_done_in;
   logic             a_tick_ff, a_tick_in;
   logic [SUM_W-1:0] a_sum_ff, a_sum_in;

   // Divide stage
   logic [PROD_W-1:0] div_prod;
   logic              b_done_ff, b_done_in;
   logic              b_tick_ff, b_tick_in;
   logic [SW-1:0]     b_avg_ff, b_avg_in;

   // Scale stage
   logic [XW-1:0] scale_x, scale_r;
   logic [QW-1:0] scale_q0;
   logic [QW-1:0] scale_q;
   logic          c_done_ff, c_done_in;
   logic          c_tick_ff, c_tick_in;
   logic [TW-1:0] c_scaled_ff, c_scaled_in;

   // Display stage
   logic [TW-1:0]    tenths_ff, tenths_in;
   logic             show_high_ff, show_high_in;
   logic [DW-1:0]    tens_digit, units_digit;
   logic [TW-1:0]    units_wide;
   avd_pkg::seg_type d_seg;
   logic             d_sel;
   logic             d_res;

   // Output register and skid entry
   logic             out_valid_ff, out_valid_in;
   avd_pkg::seg_type out_seg_ff, out_seg_in;
   logic             out_sel_ff, out_sel_in;
   logic             skid_valid_ff, skid_valid_in;
   avd_pkg::seg_type skid_seg_ff, skid_seg_in;
   logic             skid_sel_ff, skid_sel_in;

   // Advance the pipeline whenever the skid entry is free
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // Capture the request beat
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_mode_in   = in_mode_ff;
      in_sample_in = in_sample_ff;
      if (en) begin
         in_valid_in  = req_tvalid;
         in_mode_in   = req_tuser;
         in_sample_in = req_tdata[SW-1:0];
      end
   end

   // Accumulate samples, close a group every SAMPLES samples
   assign is_sample  = in_valid_ff && (in_mode_ff == avd_pkg::MODE_SAMPLE);
   assign is_tick    = in_valid_ff && (in_mode_ff == avd_pkg::MODE_REFRESH);
   assign sum_add    = sum_ff + SUM_W'(in_sample_ff);
   assign group_last = (count_ff == CNT_W'(SAMPLES - 1));

   always_comb begin
      sum_in    = sum_ff;
      count_in  = count_ff;
      a_done_in = a_done_ff;
      a_tick_in = a_tick_ff;
      a_sum_in  = a_sum_ff;
      if (en) begin
         a_done_in = is_sample && group_last;
         a_tick_in = is_tick;
         a_sum_in  = sum_add;
         if (is_sample) begin
            if (group_last) begin
               sum_in   = '0;
               count_in = '0;
            end else begin
               sum_in   = sum_add;
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   // Divide the group sum by SAMPLES through the reciprocal
   assign div_prod = PROD_W'(a_sum_ff) * PROD_W'(DIV_M);

   always_comb begin
      b_done_in = b_done_ff;
      b_tick_in = b_tick_ff;
      b_avg_in  = b_avg_ff;
      if (en) begin
         b_done_in = a_done_ff;
         b_tick_in = a_tick_ff;
         b_avg_in  = div_prod[DIV_K +: SW];
      end
   end

   // Scale to tenths: estimate by a shift, correct by one compare
   assign scale_x  = XW'(b_avg_ff) * XW'(avd_pkg::SCALE_MUL) + XW'(avd_pkg::SCALE_RND);
   assign scale_q0 = scale_x[XW-1:avd_pkg::SCALE_SHR];
   assign scale_r  = scale_x - XW'(scale_q0) * XW'(avd_pkg::SCALE_DIV);
   assign scale_q  = scale_q0 + QW'(scale_r >= XW'(avd_pkg::SCALE_DIV));

   always_comb begin
      c_done_in   = c_done_ff;
      c_tick_in   = c_tick_ff;
      c_scaled_in = c_scaled_ff;
      if (en) begin
         c_done_in   = b_done_ff;
         c_tick_in   = b_tick_ff;
         c_scaled_in = TW'(scale_q);
      end
   end

   // Split the held value into digits and pick one
   always_comb begin
      priority if (tenths_ff >= TW'(30)) tens_digit = DW'(3);
      else if (tenths_ff >= TW'(20))     tens_digit = DW'(2);
      else if (tenths_ff >= TW'(10))     tens_digit = DW'(1);
      else                               tens_digit = DW'(0);
   end

   assign units_wide  = tenths_ff - TW'(tens_digit) * TW'(10);
   assign units_digit = units_wide[DW-1:0];
   assign d_res       = en && c_tick_ff;
   assign d_sel       = show_high_ff ? avd_pkg::DIGIT_TENS : avd_pkg::DIGIT_UNITS;
   assign d_seg       = show_high_ff ? avd_pkg::digit_code(tens_digit)
                                     : avd_pkg::digit_code(units_digit);

   always_comb begin
      tenths_in    = tenths_ff;
      show_high_in = show_high_ff;
      if (en && c_done_ff) begin
         tenths_in = c_scaled_ff;
      end
      if (d_res) begin
         show_high_in = !show_high_ff;
      end
   end

   // Hold results in the output register, spill to the skid entry on stall
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_seg_in    = out_seg_ff;
      out_sel_in    = out_sel_ff;
      skid_valid_in = skid_valid_ff;
      skid_seg_in   = skid_seg_ff;
      skid_sel_in   = skid_sel_ff;
      priority if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_seg_in    = skid_seg_ff;
            out_sel_in    = skid_sel_ff;
            skid_valid_in = 1'b0;
         end
      end else if (d_res) begin
         if (!out_valid_ff || rsp_tready) begin
            out_valid_in = 1'b1;
            out_seg_in   = d_seg;
            out_sel_in   = d_sel;
         end else begin
            skid_valid_in = 1'b1;
            skid_seg_in   = d_seg;
            skid_sel_in   = d_sel;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = avd_pkg::RSP_DATA_W'(out_seg_ff);
   assign rsp_tuser  = out_sel_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         sum_ff        <= '0;
         count_ff      <= '0;
         a_done_ff     <= 1'b0;
         a_tick_ff     <= 1'b0;
         b_done_ff     <= 1'b0;
         b_tick_ff     <= 1'b0;
         c_done_ff     <= 1'b0;
         c_tick_ff     <= 1'b0;
         tenths_ff     <= '0;
         show_high_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         a_done_ff     <= a_done_in;
         a_tick_ff     <= a_tick_in;
         b_done_ff     <= b_done_in;
         b_tick_ff     <= b_tick_in;
         c_done_ff     <= c_done_in;
         c_tick_ff     <= c_tick_in;
         tenths_ff     <= tenths_in;
         show_high_ff  <= show_high_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_mode_ff   <= in_mode_in;
      in_sample_ff <= in_sample_in;
      a_sum_ff     <= a_sum_in;
      b_avg_ff     <= b_avg_in;
      c_scaled_ff  <= c_scaled_in;
      out_seg_ff   <= out_seg_in;
      out_sel_ff   <= out_sel_in;
      skid_seg_ff  <= skid_seg_in;
      skid_sel_ff  <= skid_sel_in;
   end

   // Checks
   `AVD_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid entry full while output register empty")
   `AVD_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(SAMPLES - 1), "sample count beyond group size")
   `AVD_ASSERT_SAME(a_tenths_range, clock, reset, 1'b1, tenths_ff <= TW'(avd_pkg::TENTHS_MAX), "scaled value above full scale")
   `AVD_ASSERT_NEXT(a_digit_toggle, clock, reset, d_res, show_high_ff != $past(show_high_ff), "digit select did not alternate after a refresh")
   `AVD_ASSERT_NEXT(a_stall_spill, clock, reset, d_res && out_valid_ff && !rsp_tready, skid_valid_ff, "stalled result not held in skid entry")

endmodule

`default_nettype wire

[sim/tb_averaging_voltmeter_display_core.sv]
// ----------------------------------------------------------------------------
// Testbench for averaging_voltmeter_display_core
// Streams converter samples and refresh ticks into the core and checks every
// display beat against a predictor. The predictor keeps its own group sum,
// scaled reading and digit toggle. The run covers directed extremes, random
// traffic under several idle and stall mixes, and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_averaging_voltmeter_display_core;

   localparam int unsigned RANDOM_PER_MIX = 210;
   localparam int unsigned PRESSURE_TICKS = 40;
   localparam int unsigned HOLD_CYCLES    = 200;
   localparam int unsigned QUIET_LIMIT    = 2000;
   localparam int unsigned DRAIN_CYCLES   = 12;

   // Predicts display beats and checks the ones the core returns
   class voltmeter_scoreboard;
      typedef struct packed {
         avd_pkg::seg_type segments;
         logic             digit_select;
      } display_beat_type;

      bit [11:0]        group_sum;
      int unsigned      group_count;
      bit [5:0]         tenths;
      bit               tens_next;
      display_beat_type pending_q[$];
      int unsigned      errors;
      int unsigned      checked;
      int unsigned      samples;
      int unsigned      ticks;
      int unsigned      groups;

      function new();
         group_sum   = '0;
         group_count = 0;
         tenths      = '0;
         tens_next   = 1'b0;
         errors      = 0;
         checked     = 0;
         samples     = 0;
         ticks       = 0;
         groups      = 0;
      endfunction

      // Segment pattern of one decimal digit, blank outside 0..9
      function avd_pkg::seg_type segs_of(input int unsigned d);
         case (d)
            0:       return 7'h3F;
            1:       return 7'h06;
            2:       return 7'h5B;
            3:       return 7'h4F;
            4:       return 7'h66;
            5:       return 7'h6D;
            6:       return 7'h7D;
            7:       return 7'h07;
            8:       return 7'h7F;
            9:       return 7'h6F;
            default: return 7'h00;
         endcase
      endfunction

      // Advance the prediction by one accepted request beat
      function void note_input(input logic mode, input logic [9:0] smp);
         int unsigned      avg;
         display_beat_type beat;
         if (mode == avd_pkg::MODE_SAMPLE) begin
            samples++;
            group_sum = group_sum + 12'(smp);
            group_count++;
            if (group_count >= avd_pkg::SAMPLES_DEFAULT) begin
               avg         = int'(group_sum) / avd_pkg::SAMPLES_DEFAULT;
               tenths      = 6'((avg * 33 + 511) / 1023);
               group_sum   = '0;
               group_count = 0;
               groups++;
            end
         end else begin
            ticks++;
            if (!tens_next) begin
               beat.segments     = segs_of(tenths % 10);
               beat.digit_select = avd_pkg::DIGIT_UNITS;
            end else begin
               beat.segments     = segs_of(tenths / 10);
               beat.digit_select = avd_pkg::DIGIT_TENS;
            end
            tens_next = ~tens_next;
            pending_q.push_back(beat);
         end
      endfunction

      // Compare one returned display beat with the oldest prediction
      function void check_result(input avd_pkg::seg_type segs, input logic sel);
         display_beat_type want;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected display beat: expected none, got seg=%02h sel=%0d",
                     $time, segs, sel);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         checked++;
         if (segs !== want.segments) begin
            $display("%0t: segments mismatch: expected %02h, got %02h",
                     $time, want.segments, segs);
            errors++;
         end
         if (sel !== want.digit_select) begin
            $display("%0t: digit_select mismatch: expected %0d, got %0d",
                     $time, want.digit_select, sel);
            errors++;
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [avd_pkg::REQ_DATA_W-1:0]   req_tdata;   // [9:0] sample
   logic                             req_tuser;   // [0] mode
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [avd_pkg::RSP_DATA_W-1:0]   rsp_tdata;   // [6:0] segments
   logic                             rsp_tuser;   // [0] digit_select

   voltmeter_scoreboard sb;
   int unsigned         idle_pct;
   int unsigned         stall_pct;
   bit                  hold_off_req;
   bit                  hold_off_done;
   int unsigned         hold_count;
   int unsigned         quiet_cycles;
   int                  level;

   averaging_voltmeter_display_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Offer one request beat, with random idle cycles ahead of it
   task automatic send_beat(input logic mode, input logic [9:0] smp);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(avd_pkg::REQ_DATA_W-10){1'b0}}, smp};
      do @(posedge clock); while (!req_tready);
      sb.note_input(mode, smp);
   endtask

   // Random beat: refresh ticks mixed with samples near a drifting level
   task automatic send_random_beat();
      int          pick;
      int          v;
      logic [9:0]  smp;
      if ($urandom_range(0, 15) == 0)
         level = int'($urandom_range(0, 1023));
      pick = int'($urandom_range(0, 9));
      if (pick == 0)
         smp = 10'd0;
      else if (pick == 1)
         smp = 10'd1023;
      else if (pick < 4)
         smp = 10'($urandom);
      else begin
         v = level + int'($urandom_range(0, 16)) - 8;
         if (v < 0) v = 0;
         if (v > 1023) v = 1023;
         smp = 10'(v);
      end
      if ($urandom_range(0, 99) < 45)
         send_beat(avd_pkg::MODE_REFRESH, smp);
      else
         send_beat(avd_pkg::MODE_SAMPLE, smp);
   endtask

   // Drive rsp_tready: one long hold-off on request, random stalls otherwise
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_req && !hold_off_done) begin
         rsp_tready <= 1'b0;
         hold_count = hold_count + 1;
         if (hold_count >= HOLD_CYCLES)
            hold_off_done = 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Check display beats and watch for a stalled run
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[avd_pkg::SEG_W-1:0], rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL averaging_voltmeter_display_core");
            $finish;
         end
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = avd_pkg::MODE_SAMPLE;
      rsp_tready    = 1'b0;
      idle_pct      = 0;
      stall_pct     = 0;
      hold_off_req  = 1'b0;
      hold_off_done = 1'b0;
      hold_count    = 0;
      quiet_cycles  = 0;
      level         = 512;
      sb            = new();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Display before any group completes reads 00
      send_beat(avd_pkg::MODE_REFRESH, 10'd0);
      send_beat(avd_pkg::MODE_REFRESH, 10'd1023);
      // Full-scale group gives 3.3
      repeat (4) send_beat(avd_pkg::MODE_SAMPLE, 10'd1023);
      send_beat(avd_pkg::MODE_REFRESH, 10'd0);
      send_beat(avd_pkg::MODE_REFRESH, 10'd0);
      // Partial group leaves the old reading on display
      repeat (3) send_beat(avd_pkg::MODE_SAMPLE, 10'd0);
      send_beat(avd_pkg::MODE_REFRESH, 10'd0);
      send_beat(avd_pkg::MODE_SAMPLE, 10'd0);
      send_beat(avd_pkg::MODE_REFRESH, 10'd0);
      // Alternating bit patterns, average 511
      send_beat(avd_pkg::MODE_SAMPLE, 10'h2AA);
      send_beat(avd_pkg::MODE_SAMPLE, 10'h155);
      send_beat(avd_pkg::MODE_SAMPLE, 10'h2AA);
      send_beat(avd_pkg::MODE_SAMPLE, 10'h155);
      send_beat(avd_pkg::MODE_REFRESH, 10'h3FF);
      send_beat(avd_pkg::MODE_REFRESH, 10'h3FF);
      // Remainder dropped in the divide, just under full scale
      repeat (3) send_beat(avd_pkg::MODE_SAMPLE, 10'd1023);
      send_beat(avd_pkg::MODE_SAMPLE, 10'd1022);
      send_beat(avd_pkg::MODE_REFRESH, 10'd0);

      // Random traffic under four idle and stall mixes
      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 75; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 14; stall_pct = 14; end
         endcase
         repeat (RANDOM_PER_MIX) send_random_beat();
      end

      // Hold off the receiver while ticks keep coming, so the core backs up
      idle_pct     = 0;
      stall_pct    = 0;
      hold_off_req = 1'b1;
      repeat (PRESSURE_TICKS) send_beat(avd_pkg::MODE_REFRESH, 10'($urandom));

      @(negedge clock);
      req_tvalid <= 1'b0;
      stall_pct = 30;

      // Drain the remaining display beats, then watch for strays
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d samples in %0d complete groups and %0d refresh ticks",
               sb.samples, sb.groups, sb.ticks);
      $display("Checked %0d display beats over four idle mixes and a long hold-off",
               sb.checked);
      if (sb.errors == 0)
         $display("PASS averaging_voltmeter_display_core");
      else
         $display("FAIL averaging_voltmeter_display_core");
      $finish;
   end

endmodule
